FILE: design/lfd_pkg.sv
// shared types, constants and the crc32c byte update for the log fragment deframer
`default_nettype none
package lfd_pkg;

   localparam int BLOCK_SIZE  = 32768;
   localparam int PAGE_SIZE   = 4096;
   localparam int HEADER_SIZE = 7;

   localparam int BOFF_W = $clog2(BLOCK_SIZE);
   localparam int PAGE_W = $clog2(PAGE_SIZE);
   localparam int ROOM_W = BOFF_W + 1;

   localparam logic [31:0] START_OFFSET_RESET = 32'd1;
   localparam logic [31:0] CRC_POLY           = 32'h82F63B78;
   localparam logic [31:0] CRC_INIT           = 32'hFFFFFFFF;

   // configuration register indexes
   localparam logic [1:0] CSR_START_OFFSET   = 2'd0;
   localparam logic [1:0] CSR_BATCH_CHECK    = 2'd1;
   localparam logic [1:0] CSR_RECOVER_ENABLE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
   localparam logic [2:0] ST_CRC         = 3'd2;
   localparam logic [2:0] ST_FRAG_RECORD = 3'd3;
   localparam logic [2:0] ST_FRAG_BATCH  = 3'd4;

   typedef struct packed {
      logic        restart;
      logic [31:0] start_offset;
      logic        batch_check;
      logic        recover_enable;
   } lfd_cfg_type;

   // one input byte tagged with where it sits in the file
   typedef struct packed {
      logic [7:0]        data;
      logic [31:0]       pos;
      logic [BOFF_W-1:0] boff;
      logic              page_start;
      logic              block_last;
      logic              near_end;
   } lfd_byte_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [7:0]  frag_type;
      logic [31:0] frag_offset;
      logic [2:0]  status;
      logic        last;
   } lfd_result_type;

   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic is_start(input logic [7:0] t);
      return (t[3:2] <= 2'd1) && (t[1:0] <= 2'd1);
   endfunction

endpackage
`default_nettype wire

FILE: design/lfd_front.sv
// front end: takes bytes, tags file position and block/page flags, queues them
`default_nettype none
module lfd_front import lfd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lfd_cfg_type  cfg,
   input  wire logic         push,
   input  wire logic [7:0]   in_byte,
   output logic              full,
   output logic              item_valid,
   output lfd_byte_type      item,
   input  wire logic         item_take
);
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

   lfd_byte_type            q_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [FQ_PTR_W:0]       count_ff, count_in;
   logic [31:0]             position_ff, position_in;
   logic                    accept, take;
   lfd_byte_type            byte_info;

   assign full       = (count_ff == (FQ_PTR_W+1)'(FQ_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ff];
   assign accept     = push && !full;
   assign take       = item_take && item_valid;

   // page size is a power of two, so page alignment is a mask on the low bits
   always_comb begin
      byte_info.data       = in_byte;
      byte_info.pos        = position_ff;
      byte_info.boff       = position_ff[BOFF_W-1:0];
      byte_info.page_start = (position_ff[PAGE_W-1:0] == '0);
      byte_info.block_last = (position_ff[BOFF_W-1:0] == BOFF_W'(BLOCK_SIZE - 1));
      byte_info.near_end   = (position_ff[BOFF_W-1:0] > BOFF_W'(BLOCK_SIZE - HEADER_SIZE));
   end

   always_comb begin
      wr_in       = accept ? wr_ff + FQ_PTR_W'(1) : wr_ff;
      rd_in       = take ? rd_ff + FQ_PTR_W'(1) : rd_ff;
      count_in    = count_ff + (FQ_PTR_W+1)'(accept) - (FQ_PTR_W+1)'(take);
      position_in = accept ? position_ff + 32'd1 : position_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff       <= '0;
         rd_ff       <= '0;
         count_ff    <= '0;
         position_ff <= START_OFFSET_RESET;
      end else if (cfg.restart) begin
         wr_ff       <= '0;
         rd_ff       <= '0;
         count_ff    <= '0;
         position_ff <= cfg.start_offset;
      end else begin
         wr_ff       <= wr_in;
         rd_ff       <= rd_in;
         count_ff    <= count_in;
         position_ff <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ff] <= byte_info;
      end
   end

endmodule
`default_nettype wire

FILE: design/lfd_rsp_queue.sv
// result queue: takes up to two results a cycle, hands out one
`default_nettype none
module lfd_rsp_queue import lfd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           restart,
   input  wire logic [1:0]     push_n,
   input  wire lfd_result_type push_a,
   input  wire lfd_result_type push_b,
   output logic                room2,
   output logic                empty,
   output lfd_result_type      head,
   input  wire logic           pop
);
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

   lfd_result_type          q_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]     wr_ff, rd_ff, wr_next;
   logic [RQ_PTR_W:0]       count_ff;
   logic                    take;

   assign empty   = (count_ff == '0);
   assign head    = q_ff[rd_ff];
   assign take    = pop && !empty;
   assign room2   = (count_ff <= (RQ_PTR_W+1)'(RQ_DEPTH - 2));
   assign wr_next = wr_ff + RQ_PTR_W'(1);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + RQ_PTR_W'(push_n);
         rd_ff    <= take ? rd_ff + RQ_PTR_W'(1) : rd_ff;
         count_ff <= count_ff + (RQ_PTR_W+1)'(push_n) - (RQ_PTR_W+1)'(take);
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_next] <= push_b;
      end
   end

endmodule
`default_nettype wire

FILE: design/lfd_back.sv
// back end: header parse, payload streaming, crc and fragment order checks
`default_nettype none
module lfd_back import lfd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lfd_cfg_type  cfg,
   input  wire logic         item_valid,
   input  wire lfd_byte_type item,
   output logic              item_take,
   input  wire logic         room2,
   output logic [1:0]        push_n,
   output lfd_result_type    push_a,
   output lfd_result_type    push_b
);
   localparam logic [2:0] PH_SEEK      = 3'd0;
   localparam logic [2:0] PH_TRAILER   = 3'd1;
   localparam logic [2:0] PH_HEADER    = 3'd2;
   localparam logic [2:0] PH_PAYLOAD   = 3'd3;
   localparam logic [2:0] PH_SKIPBLOCK = 3'd4;
   localparam logic [2:0] PH_HALT      = 3'd5;

   logic [2:0]        phase_ff, phase_in;
   logic [2:0]        hcount_ff, hcount_in;
   logic [31:0]       stored_ff, stored_in;
   logic [15:0]       left_ff, left_in;
   logic [31:0]       crc_ff, crc_in;
   logic [7:0]        prev_ff, prev_in;
   logic [7:0]        cur_ff, cur_in;
   logic              nonempty_ff, nonempty_in;
   logic [31:0]       hoff_ff, hoff_in;
   logic [BOFF_W-1:0] hboff_ff, hboff_in;
   logic              hunting_ff, hunting_in;

   logic              step;
   lfd_result_type    res [2];
   logic [1:0]        k;
   logic              do_finish, fin_ne, do_fail;
   logic [2:0]        fail_status;
   logic              rec_ok, bat_ok;
   logic [ROOM_W-1:0] room;
   logic [7:0]        b;

   assign item_take = room2;
   assign step      = item_valid && room2;
   assign b         = item.data;

   always_comb begin
      phase_in    = phase_ff;
      hcount_in   = hcount_ff;
      stored_in   = stored_ff;
      left_in     = left_ff;
      crc_in      = crc_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      nonempty_in = nonempty_ff;
      hoff_in     = hoff_ff;
      hboff_in    = hboff_ff;
      hunting_in  = hunting_ff;
      res[0]      = '0;
      res[1]      = '0;
      k           = 2'd0;
      do_finish   = 1'b0;
      fin_ne      = 1'b0;
      do_fail     = 1'b0;
      fail_status = ST_OK;
      rec_ok      = 1'b0;
      bat_ok      = 1'b0;
      room        = ROOM_W'(BLOCK_SIZE - HEADER_SIZE) - ROOM_W'(hboff_ff);

      case (phase_ff)
         PH_TRAILER, PH_SKIPBLOCK: begin
            if (item.block_last) begin
               phase_in = PH_SEEK;
            end
         end
         PH_HALT: begin
         end
         PH_HEADER: begin
            if (hcount_ff < 3'd4) begin
               stored_in = stored_ff | ({24'd0, b} << {hcount_ff[1:0], 3'd0});
            end else if (hcount_ff == 3'd4) begin
               cur_in = b;
               crc_in = crc32c_byte(CRC_INIT, b);
            end else begin
               crc_in = crc32c_byte(crc_ff, b);
               if (hcount_ff == 3'd5) begin
                  left_in = {left_ff[15:8], b};
               end else begin
                  left_in = {b, left_ff[7:0]};
               end
            end
            hcount_in = hcount_ff + 3'd1;
            if (hcount_ff == 3'(HEADER_SIZE - 1)) begin
               hcount_in = 3'd0;
               if ({{(32-16){1'b0}}, left_in} > {{(32-ROOM_W){1'b0}}, room}) begin
                  do_fail     = 1'b1;
                  fail_status = ST_BAD_LENGTH;
               end else if (left_in == 16'd0) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            crc_in = crc32c_byte(crc_ff, b);
            if (!hunting_ff || is_start(cur_ff)) begin
               res[0].kind        = KIND_PAYLOAD;
               res[0].data        = b;
               res[0].frag_type   = cur_ff;
               res[0].frag_offset = hoff_ff;
               res[0].status      = ST_OK;
               k                  = 2'd1;
            end
            left_in = left_ff - 16'd1;
            if (left_in == 16'd0) begin
               do_finish = 1'b1;
               fin_ne    = 1'b1;
            end
         end
         default: begin
            // pad byte after a finished non-empty record fragment at a page start
            if (item.page_start && nonempty_ff &&
                (cur_ff[3:2] == 2'd0 || cur_ff[3:2] == 2'd3)) begin
               phase_in = PH_SEEK;
            end else if (item.near_end) begin
               phase_in = item.block_last ? PH_SEEK : PH_TRAILER;
            end else begin
               phase_in  = PH_HEADER;
               hoff_in   = item.pos;
               hboff_in  = item.boff;
               stored_in = {24'd0, b};
               left_in   = 16'd0;
               hcount_in = 3'd1;
            end
         end
      endcase

      if (do_finish) begin
         rec_ok = ((prev_ff[3:2] == 2'd0 || prev_ff[3:2] == 2'd3) && cur_in[3:2] <= 2'd1) ||
                  ((prev_ff[3:2] == 2'd1 || prev_ff[3:2] == 2'd2) && cur_in[3:2] >= 2'd2 &&
                   ((prev_ff[5:4] ^ cur_in[5:4]) == 2'd0));
         bat_ok = ((prev_ff[1:0] == 2'd0 || prev_ff[1:0] == 2'd3) && cur_in[1:0] <= 2'd1) ||
                  ((prev_ff[1:0] == 2'd1 || prev_ff[1:0] == 2'd2) && cur_in[1:0] >= 2'd2);
         if ((crc_in ^ CRC_INIT) != stored_in) begin
            do_fail     = 1'b1;
            fail_status = ST_CRC;
         end else begin
            nonempty_in = fin_ne;
            phase_in    = PH_SEEK;
            if (hunting_ff && !is_start(cur_in)) begin
               // still hunting: fragment checked but dropped
            end else if (!hunting_ff && !rec_ok) begin
               do_fail     = 1'b1;
               fail_status = ST_FRAG_RECORD;
            end else if (!hunting_ff && cfg.batch_check && !bat_ok) begin
               do_fail     = 1'b1;
               fail_status = ST_FRAG_BATCH;
            end else begin
               hunting_in              = 1'b0;
               prev_in                 = cur_in;
               res[k[0]].kind          = KIND_ACCEPT;
               res[k[0]].frag_type     = cur_in;
               res[k[0]].frag_offset   = hoff_in;
               res[k[0]].status        = ST_OK;
               k                       = k + 2'd1;
            end
         end
      end

      if (do_fail) begin
         res[k[0]].kind        = KIND_ERROR;
         res[k[0]].frag_type   = cur_in;
         res[k[0]].frag_offset = hoff_in;
         res[k[0]].status      = fail_status;
         k                     = k + 2'd1;
         if (cfg.recover_enable) begin
            hunting_in  = 1'b1;
            cur_in      = 8'd0;
            nonempty_in = 1'b0;
            prev_in     = 8'd0;
            phase_in    = item.block_last ? PH_SEEK : PH_SKIPBLOCK;
         end else begin
            phase_in = PH_HALT;
         end
      end

      if (k == 2'd1) begin
         res[0].last = 1'b1;
      end else if (k == 2'd2) begin
         res[1].last = 1'b1;
      end
   end

   assign push_n = step ? k : 2'd0;
   assign push_a = res[0];
   assign push_b = res[1];

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         phase_ff    <= PH_SEEK;
         hcount_ff   <= '0;
         stored_ff   <= '0;
         left_ff     <= '0;
         crc_ff      <= CRC_INIT;
         prev_ff     <= '0;
         cur_ff      <= '0;
         nonempty_ff <= 1'b0;
         hoff_ff     <= '0;
         hboff_ff    <= '0;
         hunting_ff  <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hcount_ff   <= hcount_in;
         stored_ff   <= stored_in;
         left_ff     <= left_in;
         crc_ff      <= crc_in;
         prev_ff     <= prev_in;
         cur_ff      <= cur_in;
         nonempty_ff <= nonempty_in;
         hoff_ff     <= hoff_in;
         hboff_ff    <= hboff_in;
         hunting_ff  <= hunting_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/log_fragment_deframer_crc32c_unit.sv
// top level of the log fragment deframer with crc32c check
//
// channel   direction  handshake            payload
// req       in         push / full          req_in_byte
// rsp       out        pop / empty          rsp_kind rsp_data rsp_frag_type rsp_frag_offset
//                                           rsp_status rsp_last
// csr       in         csr_valid/csr_ready  csr_index csr_wdata
//
// one byte per cycle sustained; the back end takes a byte whenever one is queued
// and the result queue has room for two results
// a result reaches the rsp ports once its byte has been registered in the front queue
// and the back end has written the result into the result queue
// reset is synchronous and needs no clearing pass; a start_offset write restarts all but
// the csr settings; a stalled rsp side backs up into the front queue and then raises full
`default_nettype none
module log_fragment_deframer_crc32c_unit import lfd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_in_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data,
   output logic [7:0]       rsp_frag_type,
   output logic [31:0]      rsp_frag_offset,
   output logic [2:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   logic           batch_check_ff, recover_enable_ff;
   lfd_cfg_type    cfg;
   logic           wr;
   logic           item_valid, item_take, room2;
   lfd_byte_type   item;
   logic [1:0]     push_n;
   lfd_result_type push_a, push_b, head;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_check_ff    <= 1'b1;
         recover_enable_ff <= 1'b1;
      end else if (wr) begin
         case (csr_index)
            // start offset goes straight into the front end through the restart
            CSR_START_OFFSET: begin
            end
            CSR_BATCH_CHECK:    batch_check_ff    <= csr_wdata[0];
            CSR_RECOVER_ENABLE: recover_enable_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.restart        = wr && (csr_index == CSR_START_OFFSET);
      cfg.start_offset   = csr_wdata;
      cfg.batch_check    = batch_check_ff;
      cfg.recover_enable = recover_enable_ff;
   end

   lfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .push       (push),
      .in_byte    (req_in_byte),
      .full       (full),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   lfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .room2      (room2),
      .push_n     (push_n),
      .push_a     (push_a),
      .push_b     (push_b)
   );

   lfd_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .restart (cfg.restart),
      .push_n  (push_n),
      .push_a  (push_a),
      .push_b  (push_b),
      .room2   (room2),
      .empty   (empty),
      .head    (head),
      .pop     (pop)
   );

   assign rsp_kind        = head.kind;
   assign rsp_data        = head.data;
   assign rsp_frag_type   = head.frag_type;
   assign rsp_frag_offset = head.frag_offset;
   assign rsp_status      = head.status;
   assign rsp_last        = head.last;

endmodule
`default_nettype wire

FILE: design/lfd_checker.sv
// port-level checks on the deframer, bound to the top level
`default_nettype none
module lfd_checker import lfd_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic [1:0]  rsp_kind,
   input wire logic [7:0]  rsp_data,
   input wire logic [2:0]  rsp_status
);
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_kind == KIND_PAYLOAD || rsp_kind == KIND_ACCEPT ||
                  rsp_kind == KIND_ERROR))
      else $error("illegal result kind");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != KIND_ERROR) |-> rsp_status == ST_OK)
      else $error("nonzero status on payload or accept");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_ERROR) |-> (rsp_status != ST_OK && rsp_data == 8'd0))
      else $error("malformed error report");
endmodule

bind log_fragment_deframer_crc32c_unit lfd_checker u_lfd_checker (
   .clock      (clock),
   .reset      (reset),
   .empty      (empty),
   .rsp_kind   (rsp_kind),
   .rsp_data   (rsp_data),
   .rsp_status (rsp_status)
);
`default_nettype wire

FILE: tb/sv/tb_log_fragment_deframer_crc32c_unit.sv
// testbench for the log fragment deframer: byte stream in, predicted results checked out
`timescale 1ns / 1ps
module tb_log_fragment_deframer_crc32c_unit;
   import lfd_pkg::*;

   typedef enum logic [2:0] {
      P_SEEK, P_TRAILER, P_HEADER, P_PAYLOAD, P_SKIPBLOCK, P_HALT
   } deframe_phase_type;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 12;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic [7:0] req_in_byte = 0;
   logic pop = 0;
   logic csr_valid = 0;
   logic [1:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;
   logic full, empty, csr_ready;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data, rsp_frag_type;
   logic [31:0] rsp_frag_offset;
   logic [2:0] rsp_status;
   logic rsp_last;

   log_fragment_deframer_crc32c_unit DUT (.*);

   initial forever #1 clock = ~clock;

   // predictor state
   logic [31:0] cfg_start;
   logic cfg_batch, cfg_recover;
   logic [31:0] pos, stored_crc, run_crc, hdr_off;
   deframe_phase_type phase;
   int unsigned hdr_cnt;
   logic [15:0] pay_left;
   logic [7:0] prev_type, cur_type;
   logic last_nonempty, hunting;

   logic [7:0] byte_queue[$];
   lfd_result_type expected_results[$];
   lfd_result_type step_out[$];
   int errors = 0;
   bit quiet = 0;
   int idle_cycles = 0;

   function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
      c ^= {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'h82F63B78) : (c >> 1);
      return c;
   endfunction

   function automatic logic start_frag(logic [7:0] t);
      return t[3:2] <= 2'd1 && t[1:0] <= 2'd1;
   endfunction

   function automatic void restart_model(logic [31:0] p);
      pos = p; phase = P_SEEK; hdr_cnt = 0; stored_crc = 0; pay_left = 0;
      run_crc = 32'hFFFFFFFF; prev_type = 0; cur_type = 0; last_nonempty = 0;
      hdr_off = 0; hunting = 0;
   endfunction

   function automatic void emit(logic [1:0] k, logic [7:0] d, logic [2:0] st);
      lfd_result_type r;
      r.kind = k; r.data = d; r.frag_type = cur_type; r.frag_offset = hdr_off;
      r.status = st; r.last = 0;
      step_out.push_back(r);
   endfunction

   function automatic void report_error(logic [2:0] st, logic [31:0] p);
      emit(KIND_ERROR, 8'd0, st);
      if (cfg_recover) begin
         hunting = 1; cur_type = 0; last_nonempty = 0; prev_type = 0;
         phase = (p % BLOCK_SIZE == BLOCK_SIZE - 1) ? P_SEEK : P_SKIPBLOCK;
      end else phase = P_HALT;
   endfunction

   function automatic void close_fragment(logic nonempty, logic [31:0] p);
      logic [1:0] ra, rb, ba, bb;
      logic ok;
      ra = prev_type[3:2]; rb = cur_type[3:2]; ba = prev_type[1:0]; bb = cur_type[1:0];
      if ((run_crc ^ 32'hFFFFFFFF) != stored_crc) begin
         report_error(ST_CRC, p); return;
      end
      last_nonempty = nonempty;
      phase = P_SEEK;
      if (hunting) begin
         if (!start_frag(cur_type)) return;
         hunting = 0;
      end else begin
         ok = ((ra == 0 || ra == 3) && rb <= 1) ||
              ((ra == 1 || ra == 2) && rb >= 2 && ((prev_type ^ cur_type) & 8'h30) == 0);
         if (!ok) begin report_error(ST_FRAG_RECORD, p); return; end
         if (cfg_batch) begin
            ok = ((ba == 0 || ba == 3) && bb <= 1) || ((ba == 1 || ba == 2) && bb >= 2);
            if (!ok) begin report_error(ST_FRAG_BATCH, p); return; end
         end
      end
      prev_type = cur_type;
      emit(KIND_ACCEPT, 8'd0, ST_OK);
   endfunction

   function automatic void predict_byte(logic [7:0] b);
      logic [31:0] p, boff, room;
      p = pos; boff = p % BLOCK_SIZE; pos = p + 1;
      step_out.delete();
      case (phase)
         P_TRAILER, P_SKIPBLOCK: if (boff == BLOCK_SIZE - 1) phase = P_SEEK;
         P_HALT: ;
         P_HEADER: begin
            if (hdr_cnt < 4) stored_crc |= {24'd0, b} << (8 * hdr_cnt);
            else if (hdr_cnt == 4) begin
               cur_type = b; run_crc = crc_update(32'hFFFFFFFF, b);
            end else begin
               run_crc = crc_update(run_crc, b);
               pay_left |= {8'd0, b} << (8 * (hdr_cnt - 5));
            end
            hdr_cnt++;
            if (hdr_cnt == HEADER_SIZE) begin
               room = BLOCK_SIZE - (hdr_off % BLOCK_SIZE) - HEADER_SIZE;
               hdr_cnt = 0;
               if (pay_left > room) report_error(ST_BAD_LENGTH, p);
               else if (pay_left == 0) close_fragment(1'b0, p);
               else phase = P_PAYLOAD;
            end
         end
         P_PAYLOAD: begin
            run_crc = crc_update(run_crc, b);
            if (!hunting || start_frag(cur_type)) emit(KIND_PAYLOAD, b, ST_OK);
            pay_left = pay_left - 16'd1;
            if (pay_left == 0) close_fragment(1'b1, p);
         end
         default: begin
            if (p % PAGE_SIZE == 0 && last_nonempty &&
                (cur_type[3:2] == 0 || cur_type[3:2] == 3)) phase = P_SEEK;
            else if (BLOCK_SIZE - boff < HEADER_SIZE)
               phase = (boff == BLOCK_SIZE - 1) ? P_SEEK : P_TRAILER;
            else begin
               phase = P_HEADER; hdr_off = p; stored_crc = {24'd0, b};
               pay_left = 0; hdr_cnt = 1;
            end
         end
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
      foreach (step_out[i]) expected_results.push_back(step_out[i]);
   endfunction

   task automatic report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) predict_byte(req_in_byte);
         if (!(push && full)) begin
            if (byte_queue.size() > 0 && (quiet || $urandom_range(99) >= 30)) begin
               push <= 1; req_in_byte <= byte_queue.pop_front();
            end else push <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      lfd_result_type exp_r;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_results.size() == 0)
               report_mismatch($sformatf("unexpected result kind %0d", rsp_kind));
            else begin
               exp_r = expected_results.pop_front();
               if (rsp_kind !== exp_r.kind || rsp_data !== exp_r.data ||
                   rsp_frag_type !== exp_r.frag_type ||
                   rsp_frag_offset !== exp_r.frag_offset ||
                   rsp_status !== exp_r.status || rsp_last !== exp_r.last)
                  report_mismatch($sformatf(
                     "got k%0d d%h t%h o%h s%0d l%0d exp k%0d d%h t%h o%h s%0d l%0d",
                     rsp_kind, rsp_data, rsp_frag_type, rsp_frag_offset, rsp_status,
                     rsp_last, exp_r.kind, exp_r.data, exp_r.frag_type,
                     exp_r.frag_offset, exp_r.status, exp_r.last));
            end
         end
         pop <= quiet || $urandom_range(99) >= 30;
         if ((push && !full) || (pop && !empty) || csr_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // builds one fragment with a correct or deliberately broken checksum
   task automatic add_fragment(logic [7:0] t, int len, bit bad_crc);
      logic [31:0] c;
      logic [7:0] pay[$];
      c = crc_update(32'hFFFFFFFF, t);
      c = crc_update(c, len[7:0]);
      c = crc_update(c, len[15:8]);
      for (int i = 0; i < len; i++) begin
         pay.push_back(8'($urandom_range(255)));
         c = crc_update(c, pay[i]);
      end
      c = c ^ 32'hFFFFFFFF;
      if (bad_crc) c ^= 32'h1 << $urandom_range(31);
      for (int i = 0; i < 4; i++) byte_queue.push_back(c[8*i +: 8]);
      byte_queue.push_back(t);
      byte_queue.push_back(len[7:0]);
      byte_queue.push_back(len[15:8]);
      foreach (pay[i]) byte_queue.push_back(pay[i]);
   endtask

   task automatic wait_idle();
      while (byte_queue.size() > 0 || push) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx == CSR_START_OFFSET) begin
         cfg_start = val; restart_model(val);
      end else if (idx == CSR_BATCH_CHECK) cfg_batch = val[0];
      else cfg_recover = val[0];
   endtask

   // count is in bytes
   task automatic random_stream(int count);
      int r, len, cut;
      logic [7:0] t;
      for (int n = 0; n < count; ) begin
         r = $urandom_range(99);
         if (r < 75) begin
            // mostly well-formed single-fragment records
            t = (r < 55) ? 8'($urandom_range(1)) : 8'($urandom_range(255));
            len = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 12));
            add_fragment(t, len, $urandom_range(19) == 0);
            n += HEADER_SIZE + len;
         end else if (r < 90) begin
            byte_queue.push_back(8'($urandom_range(255))); n++;
         end else begin
            len = $urandom_range(1, 6);
            cut = $urandom_range(1, 5);
            add_fragment(8'($urandom_range(255)), len, 1'b0);
            repeat (cut) void'(byte_queue.pop_back());
            n += HEADER_SIZE + len - cut;
         end
      end
   endtask

   initial begin
      cfg_start = START_OFFSET_RESET; cfg_batch = 1; cfg_recover = 1;
      restart_model(cfg_start);
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default config, start offset 1
      add_fragment(8'h00, 0, 0);          // empty full record
      add_fragment(8'h05, 3, 0);          // first of record and batch
      add_fragment(8'h0A, 2, 0);          // middle
      add_fragment(8'h0F, 1, 0);          // last
      add_fragment(8'h0C, 1, 0);          // out-of-order record
      add_fragment(8'h00, 2, 1);          // checksum mismatch
      add_fragment(8'h01, 2, 0);          // batch order error or resync
      wait_idle();

      // halt mode, bad length near a block end
      write_reg(CSR_RECOVER_ENABLE, 0);
      write_reg(CSR_START_OFFSET, BLOCK_SIZE - 20);
      add_fragment(8'h00, 4, 0);          // ends 9 bytes before block end
      add_fragment(8'h00, 20, 0);         // too long for the block: error
      add_fragment(8'h00, 1, 0);          // dropped while halted
      wait_idle();

      write_reg(CSR_RECOVER_ENABLE, 1);
      write_reg(CSR_START_OFFSET, 32'hFFFFFFF0);  // position wraps
      add_fragment(8'hFF, 40, 0);
      add_fragment(8'h00, 1, 0);
      wait_idle();

      write_reg(CSR_BATCH_CHECK, 0);
      write_reg(CSR_START_OFFSET, PAGE_SIZE - 12);
      add_fragment(8'h00, 5, 0);          // ends just before a page boundary
      byte_queue.push_back(8'hFF);        // pad byte
      add_fragment(8'h03, 1, 0);
      wait_idle();

      // random phases: mixed settings, then a quiet stretch
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_BATCH_CHECK, $urandom_range(1));
         write_reg(CSR_RECOVER_ENABLE, 32'(ph != 2));
         write_reg(CSR_START_OFFSET, (ph == 1) ? BLOCK_SIZE - $urandom_range(1, 60) :
                                     (ph == 3) ? $urandom() : $urandom_range(200));
         quiet = (ph == 3);
         random_stream(80);
         wait_idle();
      end
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
